>>> rtl/iirdf1_pkg.sv
// Shared widths, register indexes and fixed-point constants for the DF-I IIR filter.
package iirdf1_pkg;

	localparam int CH_W      = 2;
	localparam int SAMPLE_W  = 16;
	localparam int OUT_W     = 32;
	localparam int COEF_W    = 24;
	localparam int REG_W     = 48;
	localparam int CFG_IDX_W = 3;
	localparam int MAX_ORDER = 4;

	// Accumulator holds 28 fraction bits; inputs are scaled up by FF_SCALE
	localparam int ACC_W    = 64;
	localparam int FF_SCALE = 8;
	localparam int ACC_SHR  = 20;
	localparam int SHR_W    = ACC_W - ACC_SHR;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_B0_B1 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_B2_B3 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B4_A1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_A2_A3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_A4    = 3'd4;

	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [OUT_W-1:0]    out_t;

endpackage

>>> rtl/iirdf1_if.sv
// Request channel interfaces: sample input, filtered result and coefficient writes.
interface iirdf1_in_if;
	logic                          valid;
	logic                          ready;
	logic [iirdf1_pkg::CH_W-1:0]   channel;
	iirdf1_pkg::sample_t           sample;

	modport source (output valid, channel, sample, input ready);
	modport sink   (input valid, channel, sample, output ready);
endinterface

interface iirdf1_out_if;
	logic                          valid;
	logic                          ready;
	logic [iirdf1_pkg::CH_W-1:0]   channel_out;
	iirdf1_pkg::out_t              filtered;
	logic                          saturated;

	modport source (output valid, channel_out, filtered, saturated, input ready);
	modport sink   (input valid, channel_out, filtered, saturated, output ready);
endinterface

interface iirdf1_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [iirdf1_pkg::CFG_IDX_W-1:0]   index;
	logic [iirdf1_pkg::REG_W-1:0]       data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/iir_direct_form_one_filter.sv
// A sample request is captured in the input stage register, and its result moves on into
// the result register once that register is free or drains, then waits there to be taken.
// Throughput: one sample per cycle unless results are stalled; the input stage can take
// a new request while a finished result waits. The row of the request's channel is read,
// multiplied in parallel and summed in one pass between input and result registers.
// Reset clears coefficients, both delay lines of every channel and all valid flags.
module iir_direct_form_one_filter #(
	parameter int FILTER_ORDER = 4,
	parameter int NUM_CHANNELS = 3
) (
	input  logic            clk,
	input  logic            arst_n,
	iirdf1_cfg_if.sink      cfg,
	iirdf1_in_if.sink       samples,
	iirdf1_out_if.source    results
);

	localparam int PB_W = iirdf1_pkg::COEF_W + iirdf1_pkg::SAMPLE_W;
	localparam int PA_W = iirdf1_pkg::COEF_W + iirdf1_pkg::OUT_W;

	// Coefficient registers
	logic [iirdf1_pkg::REG_W-1:0] coef_b0_b1_q;
	logic [iirdf1_pkg::REG_W-1:0] coef_b2_b3_q;
	logic [iirdf1_pkg::REG_W-1:0] coef_b4_a1_q;
	logic [iirdf1_pkg::REG_W-1:0] coef_a2_a3_q;
	iirdf1_pkg::coef_t            coef_a4_q;

	iirdf1_pkg::coef_t b_c [iirdf1_pkg::MAX_ORDER+1];
	iirdf1_pkg::coef_t a_c [iirdf1_pkg::MAX_ORDER];

	// Input stage
	logic                          valid_s1;
	logic [iirdf1_pkg::CH_W-1:0]   channel_s1;
	iirdf1_pkg::sample_t           sample_s1;

	// Delay lines, one row per channel
	iirdf1_pkg::sample_t x_hist_q [NUM_CHANNELS][FILTER_ORDER];
	iirdf1_pkg::out_t    y_hist_q [NUM_CHANNELS][FILTER_ORDER];
	iirdf1_pkg::sample_t x_row [FILTER_ORDER];
	iirdf1_pkg::out_t    y_row [FILTER_ORDER];

	logic signed [PB_W-1:0] prod_b [FILTER_ORDER+1];
	logic signed [PA_W-1:0] prod_a [FILTER_ORDER];
	logic signed [iirdf1_pkg::ACC_W-1:0] acc;
	logic signed [iirdf1_pkg::SHR_W-1:0] shifted;
	logic                   ovf;
	logic                   in_range;
	iirdf1_pkg::out_t       y_next;
	iirdf1_pkg::out_t       filtered_next;
	logic                   sat_next;

	// Result register
	logic                          out_valid_q;
	logic [iirdf1_pkg::CH_W-1:0]   channel_out_q;
	iirdf1_pkg::out_t              filtered_q;
	logic                          saturated_q;

	logic advance;

	// Coefficient writes; indexes past the register list are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_b0_b1_q <= '0;
			coef_b2_b3_q <= '0;
			coef_b4_a1_q <= '0;
			coef_a2_a3_q <= '0;
			coef_a4_q    <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				iirdf1_pkg::REG_B0_B1: coef_b0_b1_q <= cfg.data;
				iirdf1_pkg::REG_B2_B3: coef_b2_b3_q <= cfg.data;
				iirdf1_pkg::REG_B4_A1: coef_b4_a1_q <= cfg.data;
				iirdf1_pkg::REG_A2_A3: coef_a2_a3_q <= cfg.data;
				iirdf1_pkg::REG_A4:    coef_a4_q    <= cfg.data[iirdf1_pkg::COEF_W-1:0];
				default: ;
			endcase
		end
	end

	// Unpack the coefficient pairs
	localparam int CW = iirdf1_pkg::COEF_W;
	assign b_c[0] = coef_b0_b1_q[CW-1:0];
	assign b_c[1] = coef_b0_b1_q[2*CW-1:CW];
	assign b_c[2] = coef_b2_b3_q[CW-1:0];
	assign b_c[3] = coef_b2_b3_q[2*CW-1:CW];
	assign b_c[4] = coef_b4_a1_q[CW-1:0];
	assign a_c[0] = coef_b4_a1_q[2*CW-1:CW];
	assign a_c[1] = coef_a2_a3_q[CW-1:0];
	assign a_c[2] = coef_a2_a3_q[2*CW-1:CW];
	assign a_c[3] = coef_a4_q;

	// Handshake: the input stage moves on when the result register is free or drains
	assign advance       = valid_s1 && (!out_valid_q || results.ready);
	assign samples.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			channel_s1 <= samples.channel;
			sample_s1  <= samples.sample;
		end
	end

	// Select the delay-line row of the request's channel
	assign in_range = int'(channel_s1) < NUM_CHANNELS;

	always_comb begin
		for (int k = 0; k < FILTER_ORDER; k++) begin
			x_row[k] = '0;
			y_row[k] = '0;
		end
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			if (int'(channel_s1) == c) begin
				x_row = x_hist_q[c];
				y_row = y_hist_q[c];
			end
		end
	end

	// Parallel tap products
	always_comb begin
		prod_b[0] = b_c[0] * sample_s1;
		for (int k = 1; k <= FILTER_ORDER; k++) begin
			prod_b[k]   = b_c[k] * x_row[k-1];
			prod_a[k-1] = a_c[k-1] * y_row[k-1];
		end
	end

	// Sum feedforward terms scaled to Q.28, subtract feedback terms
	always_comb begin
		acc = iirdf1_pkg::ACC_W'(prod_b[0]) <<< iirdf1_pkg::FF_SCALE;
		for (int k = 1; k <= FILTER_ORDER; k++) begin
			acc = acc + (iirdf1_pkg::ACC_W'(prod_b[k]) <<< iirdf1_pkg::FF_SCALE)
				- iirdf1_pkg::ACC_W'(prod_a[k-1]);
		end
	end

	// Floor shift back to Q.8 and clip to 32 bits
	assign shifted = acc[iirdf1_pkg::ACC_W-1:iirdf1_pkg::ACC_SHR];
	assign ovf = shifted[iirdf1_pkg::SHR_W-2:iirdf1_pkg::OUT_W-1]
		!= {(iirdf1_pkg::SHR_W-iirdf1_pkg::OUT_W){shifted[iirdf1_pkg::SHR_W-1]}};

	always_comb begin
		if (ovf) begin
			y_next = shifted[iirdf1_pkg::SHR_W-1] ? iirdf1_pkg::OUT_MIN : iirdf1_pkg::OUT_MAX;
		end else begin
			y_next = shifted[iirdf1_pkg::OUT_W-1:0];
		end
		filtered_next = in_range ? y_next : '0;
		sat_next      = in_range && ovf;
	end

	// Shift the selected channel's delay lines as its result is stored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				for (int k = 0; k < FILTER_ORDER; k++) begin
					x_hist_q[c][k] <= '0;
					y_hist_q[c][k] <= '0;
				end
			end
		end else if (advance && in_range) begin
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				if (int'(channel_s1) == c) begin
					for (int k = 1; k < FILTER_ORDER; k++) begin
						x_hist_q[c][k] <= x_hist_q[c][k-1];
						y_hist_q[c][k] <= y_hist_q[c][k-1];
					end
					x_hist_q[c][0] <= sample_s1;
					y_hist_q[c][0] <= y_next;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			channel_out_q <= channel_s1;
			filtered_q    <= filtered_next;
			saturated_q   <= sat_next;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.channel_out = channel_out_q;
	assign results.filtered    = filtered_q;
	assign results.saturated   = saturated_q;

endmodule

>>> rtl/iirdf1_checker.sv
// Port-level checks for the DF-I IIR filter, bound to the top level.
module iirdf1_checker #(
	parameter int NUM_CHANNELS = 3
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              res_valid,
	input logic                              res_ready,
	input logic [iirdf1_pkg::CH_W-1:0]       res_channel,
	input logic signed [iirdf1_pkg::OUT_W-1:0] res_filtered,
	input logic                              res_saturated
);

	// A stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result request dropped while stalled");

	// A clipped result sits on one of the two bounds
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_saturated |->
			(res_filtered == iirdf1_pkg::OUT_MAX) || (res_filtered == iirdf1_pkg::OUT_MIN))
		else $error("saturation flag without a clipped value");

	// A channel outside the range gives an empty result
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (int'(res_channel) >= NUM_CHANNELS) |->
			(res_filtered == '0) && !res_saturated)
		else $error("out-of-range channel produced a value");

	// With the result side empty, an accepted sample shows a result after the input stage register
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !res_valid |=> ##1 res_valid)
		else $error("result missing two cycles after request");

endmodule

bind iir_direct_form_one_filter iirdf1_checker #(
	.NUM_CHANNELS(NUM_CHANNELS)
) u_iirdf1_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (samples.valid),
	.in_ready      (samples.ready),
	.res_valid     (results.valid),
	.res_ready     (results.ready),
	.res_channel   (results.channel_out),
	.res_filtered  (results.filtered),
	.res_saturated (results.saturated)
);

>>> tb/sv/tb.sv
// Self-checking testbench for the three-channel direct-form-I IIR filter.
module tb;
	import iirdf1_pkg::*;

	localparam int ORDER           = 4;
	localparam int NUM_CH          = 3;
	localparam int NUM_REGS        = int'(REG_A4) + 1;
	localparam int STALL_LIMIT     = 4000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int PHASE_ITEMS     = 190;

	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam coef_t   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
	localparam coef_t   COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
	localparam logic [CH_W-1:0] NO_CHANNEL = CH_W'(NUM_CH);

	// Fourth-order low-pass taps in Q3.20
	localparam coef_t LP_B0 = coef_t'(839);
	localparam coef_t LP_B1 = coef_t'(3355);
	localparam coef_t LP_B2 = coef_t'(5033);
	localparam coef_t LP_B3 = coef_t'(3355);
	localparam coef_t LP_B4 = coef_t'(839);
	localparam coef_t LP_A1 = coef_t'(-3164217);
	localparam coef_t LP_A2 = coef_t'(3677541);
	localparam coef_t LP_A3 = coef_t'(-1937351);
	localparam coef_t LP_A4 = coef_t'(388812);

	typedef enum {
		SET_ZERO, SET_MAX, SET_MIN, SET_LOWPASS, SET_GROWTH, SET_MILD, SET_RANDOM
	} setting_e;

	typedef enum {RX_ALWAYS, RX_PATTERN, RX_COIN} rx_mode_e;

	typedef struct {
		logic [CH_W-1:0] channel;
		out_t            filtered;
		logic            saturated;
	} filter_result_t;

	// Coefficient copy, per-channel delay lines and the queue of pending outputs
	class df1_scoreboard;
		logic [REG_W-1:0] coef_regs [NUM_REGS];
		sample_t          x_hist [NUM_CH][ORDER];
		out_t             y_hist [NUM_CH][ORDER];
		filter_result_t   pending_outputs [$];
		int               mismatches;

		function new();
			foreach (coef_regs[i])
				coef_regs[i] = '0;
			foreach (x_hist[c, k]) begin
				x_hist[c][k] = '0;
				y_hist[c][k] = '0;
			end
			mismatches = 0;
		endfunction

		function void write_coef(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
			if (idx == REG_A4)
				coef_regs[idx] = {{(REG_W-COEF_W){1'b0}}, data[COEF_W-1:0]};
			else if (idx < REG_A4)
				coef_regs[idx] = data;
		endfunction

		// Tap n of the packed sequence b0..b4, a1..a4
		function coef_t tap(int n);
			logic [REG_W-1:0] r;
			r = coef_regs[n / 2];
			if (n % 2)
				return r[2*COEF_W-1:COEF_W];
			return r[COEF_W-1:0];
		endfunction

		function filter_result_t df1_response(logic [CH_W-1:0] ch, sample_t smp);
			filter_result_t   res;
			logic signed [ACC_W-1:0] acc, c, v, y_wide;
			res.channel   = ch;
			res.filtered  = '0;
			res.saturated = 1'b0;
			if (ch >= NUM_CH)
				return res;

			// Sum feedforward products at Q.28 and subtract feedback products
			c = tap(0);
			v = smp;
			acc = (c * v) <<< FF_SCALE;
			for (int k = 1; k <= ORDER; k++) begin
				c = tap(k);
				v = x_hist[ch][k-1];
				acc = acc + ((c * v) <<< FF_SCALE);
				c = tap(MAX_ORDER + k);
				v = y_hist[ch][k-1];
				acc = acc - c * v;
			end

			// Drop to Q.8 with floor, then clip to 32 bits
			y_wide = acc >>> ACC_SHR;
			if (y_wide > OUT_MAX) begin
				res.filtered  = OUT_MAX;
				res.saturated = 1'b1;
			end else if (y_wide < OUT_MIN) begin
				res.filtered  = OUT_MIN;
				res.saturated = 1'b1;
			end else begin
				res.filtered = y_wide[OUT_W-1:0];
			end

			// Advance the channel's delay lines
			for (int k = ORDER - 1; k > 0; k--) begin
				x_hist[ch][k] = x_hist[ch][k-1];
				y_hist[ch][k] = y_hist[ch][k-1];
			end
			x_hist[ch][0] = smp;
			y_hist[ch][0] = res.filtered;
			return res;
		endfunction

		function void note_sample(logic [CH_W-1:0] ch, sample_t smp);
			pending_outputs.push_back(df1_response(ch, smp));
		endfunction

		function void check_output(logic [CH_W-1:0] ch, out_t y, logic sat);
			filter_result_t exp_res;
			if (pending_outputs.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected output, expected none, actual ch %0d y %0d sat %0b",
					$time, ch, y, sat);
				return;
			end
			exp_res = pending_outputs.pop_front();
			if (ch !== exp_res.channel) begin
				mismatches++;
				$display("%0t: channel_out mismatch, expected %0d, actual %0d",
					$time, exp_res.channel, ch);
			end
			if (y !== exp_res.filtered) begin
				mismatches++;
				$display("%0t: filtered mismatch, expected %0d, actual %0d",
					$time, exp_res.filtered, y);
			end
			if (sat !== exp_res.saturated) begin
				mismatches++;
				$display("%0t: saturated mismatch, expected %0b, actual %0b",
					$time, exp_res.saturated, sat);
			end
		endfunction

		function int pending();
			return pending_outputs.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	iirdf1_cfg_if cfg_bus ();
	iirdf1_in_if  in_bus ();
	iirdf1_out_if out_bus ();

	df1_scoreboard sb;
	int            hold_request;

	iir_direct_form_one_filter #(
		.FILTER_ORDER(ORDER),
		.NUM_CHANNELS(NUM_CH)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_bus),
		.samples (in_bus),
		.results (out_bus)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic sample_t rand_sample();
		case ($urandom_range(0, 7))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return sample_t'(int'($urandom_range(0, 127)) - 64);
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic logic [CH_W-1:0] rand_channel();
		if ($urandom_range(0, 15) == 0)
			return NO_CHANNEL;
		return CH_W'($urandom_range(0, NUM_CH - 1));
	endfunction

	// Offer one sample and hold it until the request is taken
	task automatic send_sample(logic [CH_W-1:0] ch, sample_t smp);
		@(negedge clk);
		in_bus.valid   <= 1'b1;
		in_bus.channel <= ch;
		in_bus.sample  <= smp;
		@(posedge clk);
		while (!in_bus.ready)
			@(posedge clk);
		sb.note_sample(ch, smp);
	endtask

	task automatic idle_sender(int cycles);
		repeat (cycles) begin
			@(negedge clk);
			in_bus.valid <= 1'b0;
		end
	endtask

	// Drop valid and wait until every pending output has come back
	task automatic wait_for_outputs();
		@(negedge clk);
		in_bus.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic write_coef(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
		@(negedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		@(posedge clk);
		while (!cfg_bus.ready)
			@(posedge clk);
		sb.write_coef(idx, data);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	// Load one coefficient setting into all registers
	task automatic load_setting(setting_e kind);
		coef_t b [ORDER+1];
		coef_t a [ORDER+1];
		logic [CFG_IDX_W-1:0] spare_idx;
		for (int k = 0; k <= ORDER; k++) begin
			case (kind)
				SET_ZERO: begin
					b[k] = '0;
					a[k] = '0;
				end
				SET_MAX: begin
					b[k] = COEF_MAX;
					a[k] = COEF_MAX;
				end
				SET_MIN: begin
					b[k] = COEF_MIN;
					a[k] = COEF_MIN;
				end
				SET_GROWTH: begin
					b[k] = COEF_MAX;
					a[k] = COEF_MIN;
				end
				SET_MILD: begin
					b[k] = coef_t'($urandom);
					a[k] = coef_t'(int'($urandom_range(0, 8191)) - 4096);
				end
				SET_RANDOM: begin
					b[k] = coef_t'($urandom);
					a[k] = coef_t'($urandom);
				end
				default: begin
					b[k] = '0;
					a[k] = '0;
				end
			endcase
		end
		if (kind == SET_LOWPASS) begin
			b = '{LP_B0, LP_B1, LP_B2, LP_B3, LP_B4};
			a = '{'0, LP_A1, LP_A2, LP_A3, LP_A4};
		end
		write_coef(REG_B0_B1, {b[1], b[0]});
		write_coef(REG_B2_B3, {b[3], b[2]});
		write_coef(REG_B4_A1, {a[1], b[4]});
		write_coef(REG_A2_A3, {a[3], a[2]});
		write_coef(REG_A4, {coef_t'($urandom), a[4]});
		// Poke an unused index, which must leave the taps alone
		if (kind == SET_RANDOM || kind == SET_MILD) begin
			spare_idx = REG_A4 + CFG_IDX_W'($urandom_range(1, 3));
			write_coef(spare_idx, REG_W'({$urandom, $urandom}));
		end
	endtask

	task automatic run_items(int count, bit bursty);
		int burst_left;
		int i;
		burst_left = $urandom_range(1, 40);
		for (i = 0; i < count; i++) begin
			send_sample(rand_channel(), rand_sample());
			burst_left--;
			if (bursty && burst_left <= 0) begin
				idle_sender($urandom_range(1, 12));
				burst_left = $urandom_range(1, 40);
			end
		end
	endtask

	// Receiver: stall on a rotating pattern, coin flips, or a requested hold-off
	initial begin : receiver
		int       stall_left;
		int       mode_left;
		rx_mode_e mode;
		logic [15:0] pattern;
		stall_left    = 0;
		mode_left     = 0;
		mode          = RX_ALWAYS;
		pattern       = '1;
		out_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				stall_left   = hold_request;
				hold_request = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_bus.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_e'($urandom_range(0, 2));
					pattern   = 16'($urandom);
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				case (mode)
					RX_ALWAYS: out_bus.ready <= 1'b1;
					RX_PATTERN: begin
						out_bus.ready <= pattern[0];
						pattern = {pattern[0], pattern[15:1]};
					end
					default: out_bus.ready <= 1'($urandom_range(0, 1));
				endcase
			end
		end
	end

	// Check every output taken at a rising edge
	initial begin : output_monitor
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
				sb.check_output(out_bus.channel_out, out_bus.filtered, out_bus.saturated);
		end
	end

	// End the run when no request moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
				(out_bus.valid === 1'b1 && out_bus.ready === 1'b1) ||
				(cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: FAIL");
		$finish;
	end

	// Main sequence: reset, directed items, then random phases
	initial begin : stimulus
		setting_e schedule [8];
		bit       bursty;
		schedule = '{SET_ZERO, SET_LOWPASS, SET_MAX, SET_RANDOM,
			SET_MIN, SET_MILD, SET_RANDOM, SET_LOWPASS};
		sb             = new();
		hold_request   = 0;
		arst_n         = 1'b0;
		in_bus.valid   = 1'b0;
		in_bus.channel = '0;
		in_bus.sample  = '0;
		cfg_bus.valid  = 1'b0;
		cfg_bus.index  = '0;
		cfg_bus.data   = '0;
		repeat (12)
			@(negedge clk);
		arst_n = 1'b1;

		// Extremes of the sample and an out-of-range channel under a stable filter
		load_setting(SET_LOWPASS);
		send_sample(CH_W'(0), SAMPLE_MAX);
		send_sample(CH_W'(0), SAMPLE_MIN);
		send_sample(CH_W'(0), '0);
		send_sample(CH_W'(1), sample_t'(1));
		send_sample(CH_W'(1), sample_t'(-1));
		send_sample(CH_W'(2), SAMPLE_MAX);
		send_sample(CH_W'(2), SAMPLE_MIN);
		send_sample(NO_CHANNEL, SAMPLE_MAX);
		send_sample(NO_CHANNEL, SAMPLE_MIN);
		send_sample(CH_W'(0), sample_t'(12345));
		wait_for_outputs();

		// Runaway feedback drives one channel to each clip bound
		load_setting(SET_GROWTH);
		repeat (6)
			send_sample(CH_W'(0), SAMPLE_MAX);
		repeat (6)
			send_sample(CH_W'(1), SAMPLE_MIN);
		send_sample(NO_CHANNEL, sample_t'(-1));
		wait_for_outputs();

		// Random phases, each under its own coefficient setting
		foreach (schedule[p]) begin
			load_setting(schedule[p]);
			bursty = ($urandom_range(0, 3) != 0);
			if (p == 2)
				hold_request = HOLD_OFF_CYCLES;
			if (p == 4) begin
				run_items(PHASE_ITEMS / 2, bursty);
				wait_for_outputs();
				run_items(PHASE_ITEMS / 2, bursty);
			end else begin
				run_items(PHASE_ITEMS, bursty);
			end
			wait_for_outputs();
		end

		repeat (8)
			@(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
